FILE: design/tabq_pkg.sv
package tabq_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS = 18;
	localparam int NUM_ACCEL = 3;
	localparam int NUM_GYRO = 3;
	localparam int DATA_BITS = (NUM_ACCEL + NUM_GYRO) * SAMPLE_BITS;
	localparam int GYRO_BITS = NUM_GYRO * SAMPLE_BITS;
	localparam int CFG_IDX_BITS = 2;

	localparam int AXES_DEFAULT = 3;
	localparam int FRAC_BITS_DEFAULT = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 2'd2;

	typedef struct packed {
		logic load_in;
		logic mul;
		logic upd;
		logic acc;
		logic load_out;
	} ctrl_cmd_t;

endpackage

FILE: design/three_axis_biquad_lowpass.sv
// Three-axis second-order low-pass filter for IMU samples. Each beat carries three
// accelerometer and three gyro samples; each accelerometer axis runs through its own
// direct-form-II biquad with taps b0, 2*b0, b0 and feedback a1, a2 (signed Q2.16
// registers, to be written through the cfg port only while the block is idle, which the
// block does not enforce), the gyro samples are passed through. A new delay value that
// overflows the state width is replaced by the input sample; outputs truncate toward zero
// and saturate to 16 bits. Each item runs through feedback multiply, state update,
// feedforward multiply and output load, sequenced by one controller with a dedicated lane
// of multipliers per axis. No new beat is taken before the output step, where the next
// beat is accepted as the result is loaded; a stalled output holds the block.
module three_axis_biquad_lowpass
	import tabq_pkg::*;
#(
	parameter int AXES = AXES_DEFAULT,
	parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COEF_BITS-1:0]    cfg_wdata,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
	input  logic [DATA_BITS-1:0]    s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// filtered_x, filtered_y, filtered_z, gyro_x_out, gyro_y_out, gyro_z_out
	output logic [DATA_BITS-1:0]    m_tdata
);

	ctrl_cmd_t cmd;

	tabq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	tabq_dp #(
		.AXES      (AXES),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.out_data  (m_tdata)
	);

endmodule

FILE: design/tabq_ctrl.sv
module tabq_ctrl
	import tabq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output ctrl_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       out_valid_q;
	logic       out_free;
	logic       in_acc;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) || ((state_q == ST_OUT) && out_free);
	assign in_acc = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd.load_in  = in_acc;
		cmd.mul      = (state_q == ST_MUL);
		cmd.upd      = (state_q == ST_UPD);
		cmd.acc      = (state_q == ST_ACC);
		cmd.load_out = (state_q == ST_OUT) && out_free;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc)
					state_next = ST_MUL;
			end
			ST_MUL: state_next = ST_UPD;
			ST_UPD: state_next = ST_ACC;
			ST_ACC: state_next = ST_OUT;
			ST_OUT: begin
				if (out_free)
					state_next = in_acc ? ST_MUL : ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_accept_starts_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_MUL)
		else $error("accepted beat did not start the multiply step");
	a_acc_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |-> $past(state_q) == ST_UPD)
		else $error("feedforward step entered out of order");
	a_stall_holds_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !out_free) |=> state_q == ST_OUT)
		else $error("result left output step while output register was full");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

FILE: design/tabq_dp.sv
module tabq_dp
	import tabq_pkg::*;
#(
	parameter int AXES = AXES_DEFAULT,
	parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_cmd_t               cmd,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COEF_BITS-1:0]    cfg_wdata,
	input  logic [DATA_BITS-1:0]    in_data,
	output logic [DATA_BITS-1:0]    out_data
);

	localparam int LANES = (AXES < NUM_ACCEL) ? AXES : NUM_ACCEL;
	localparam int STATE_W = COEF_BITS + FRAC_BITS;
	localparam int PROD_W = STATE_W + COEF_BITS;
	localparam int FB_W = PROD_W + 1;
	localparam int W_W = FB_W + 1;
	localparam int SUM_W = STATE_W + 2;
	localparam int ACC_W = SUM_W + COEF_BITS;
	localparam int SAT_LO = SAMPLE_BITS - 1;

	logic signed [COEF_BITS-1:0] b0_q;
	logic signed [COEF_BITS-1:0] a1_q;
	logic signed [COEF_BITS-1:0] a2_q;
	logic [GYRO_BITS-1:0] gyro_q;
	logic [NUM_ACCEL-1:0][SAMPLE_BITS-1:0] y_lane;
	logic [DATA_BITS-1:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_B0: b0_q <= cfg_wdata;
				REG_A1: a1_q <= cfg_wdata;
				REG_A2: a2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			gyro_q <= in_data[DATA_BITS-1:NUM_ACCEL*SAMPLE_BITS];
	end

	for (genvar ax = 0; ax < NUM_ACCEL; ax++) begin : g_lane
		if (ax < LANES) begin : g_on
			logic signed [SAMPLE_BITS-1:0] x_q;
			logic signed [STATE_W-1:0] d1_q;
			logic signed [STATE_W-1:0] d2_q;
			logic signed [PROD_W-1:0] p1_s1;
			logic signed [PROD_W-1:0] p2_s1;
			logic signed [SUM_W-1:0] sum_s2;
			logic signed [ACC_W-1:0] acc_s3;
			logic signed [FB_W-1:0] fb;
			logic signed [FB_W-1:0] fb_rnd;
			logic signed [FB_W-1:0] fb_t;
			logic signed [W_W-1:0] scaled_x;
			logic signed [W_W-1:0] w_full;
			logic signed [STATE_W-1:0] w0;
			logic signed [SUM_W-1:0] sum;
			logic signed [ACC_W-1:0] acc_rnd;
			logic signed [ACC_W-1:0] y_full;
			logic w_fits;
			logic y_fits;

			always_comb begin
				fb = FB_W'(p1_s1) + FB_W'(p2_s1);
				// bias negatives so the shift truncates toward zero
				fb_rnd = fb + {{(FB_W-FRAC_BITS){1'b0}}, {FRAC_BITS{fb[FB_W-1]}}};
				fb_t = fb_rnd >>> FRAC_BITS;
				scaled_x = W_W'(x_q) <<< FRAC_BITS;
				w_full = scaled_x - W_W'(fb_t);
				w_fits = (&w_full[W_W-1:STATE_W-1]) || !(|w_full[W_W-1:STATE_W-1]);
				w0 = w_fits ? w_full[STATE_W-1:0] : scaled_x[STATE_W-1:0];
				sum = SUM_W'(w0) + (SUM_W'(d1_q) <<< 1) + SUM_W'(d2_q);
				acc_rnd = acc_s3
					+ {{(ACC_W-2*FRAC_BITS){1'b0}}, {(2*FRAC_BITS){acc_s3[ACC_W-1]}}};
				y_full = acc_rnd >>> (2 * FRAC_BITS);
				y_fits = (&y_full[ACC_W-1:SAT_LO]) || !(|y_full[ACC_W-1:SAT_LO]);
				if (y_fits)
					y_lane[ax] = y_full[SAMPLE_BITS-1:0];
				else if (y_full[ACC_W-1])
					y_lane[ax] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
				else
					y_lane[ax] = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					d1_q <= '0;
					d2_q <= '0;
				end else if (cmd.upd) begin
					d2_q <= d1_q;
					d1_q <= w0;
				end
			end

			always_ff @(posedge clk) begin
				if (cmd.load_in)
					x_q <= in_data[ax*SAMPLE_BITS +: SAMPLE_BITS];
				if (cmd.mul) begin
					p1_s1 <= d1_q * a1_q;
					p2_s1 <= d2_q * a2_q;
				end
				if (cmd.upd)
					sum_s2 <= sum;
				if (cmd.acc)
					acc_s3 <= sum_s2 * b0_q;
			end
		end else begin : g_off
			always_comb y_lane[ax] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			out_q <= {gyro_q, y_lane};
	end

	assign out_data = out_q;

endmodule

FILE: tb/tb_three_axis_biquad_lowpass.sv
`timescale 1ns / 1ps

module tb_three_axis_biquad_lowpass;
	import tabq_pkg::*;

	localparam int FRAC = FRAC_BITS_DEFAULT;
	localparam int STATE_BITS = COEF_BITS + FRAC;
	localparam longint Q_ONE = 64'sd1 <<< FRAC;
	localparam longint STATE_LIM = 64'sd1 <<< (STATE_BITS - 1);
	localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 2'd3;
	localparam int IDLE_GAP = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT = 450;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 130;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] gyro_z;
		logic signed [SAMPLE_BITS-1:0] gyro_y;
		logic signed [SAMPLE_BITS-1:0] gyro_x;
		logic signed [SAMPLE_BITS-1:0] accel_z;
		logic signed [SAMPLE_BITS-1:0] accel_y;
		logic signed [SAMPLE_BITS-1:0] accel_x;
	} imu_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] gyro_z_out;
		logic signed [SAMPLE_BITS-1:0] gyro_y_out;
		logic signed [SAMPLE_BITS-1:0] gyro_x_out;
		logic signed [SAMPLE_BITS-1:0] filtered_z;
		logic signed [SAMPLE_BITS-1:0] filtered_y;
		logic signed [SAMPLE_BITS-1:0] filtered_x;
	} imu_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [COEF_BITS-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DATA_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DATA_BITS-1:0] m_tdata;

	imu_in_t pend_q[$];
	imu_out_t imu_out_q[$];

	longint coef_b0, coef_a1, coef_a2;
	longint delay_one[3];
	longint delay_two[3];

	bit beat_taken;
	bit held;
	int hold_left;
	int sent_cnt;
	int err_cnt;
	int cycle_cnt;

	int b0_tab[PHASES] = '{4424, 0, -1, 19196, -1, -1, -131072, 131071};
	int a1_tab[PHASES] = '{-74898, 0, -1, 0, -1, -1, -131072, 131071};
	int a2_tab[PHASES] = '{27054, 0, -1, 11247, -1, -1, -131072, 131071};

	three_axis_biquad_lowpass dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic signed [SAMPLE_BITS-1:0] run_section(int ax,
			logic signed [SAMPLE_BITS-1:0] x);
		longint d1, d2, xs, fb, w0, acc, y;
		d1 = delay_one[ax];
		d2 = delay_two[ax];
		xs = longint'(x) * Q_ONE;
		fb = d1 * coef_a1 + d2 * coef_a2;
		w0 = xs - fb / Q_ONE;
		if (w0 < -STATE_LIM || w0 >= STATE_LIM)
			w0 = xs;
		acc = (w0 + 2 * d1 + d2) * coef_b0;
		y = acc / (Q_ONE * Q_ONE);
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		delay_two[ax] = d1;
		delay_one[ax] = w0;
		return y[SAMPLE_BITS-1:0];
	endfunction

	function automatic imu_out_t biquad_step(imu_in_t beat);
		imu_out_t res;
		res.filtered_x = run_section(0, beat.accel_x);
		res.filtered_y = run_section(1, beat.accel_y);
		res.filtered_z = run_section(2, beat.accel_z);
		res.gyro_x_out = beat.gyro_x;
		res.gyro_y_out = beat.gyro_y;
		res.gyro_z_out = beat.gyro_z;
		return res;
	endfunction

	function automatic int tx_idle_pct();
		return sent_cnt < 350 ? 21 : (sent_cnt < 700 ? 55 : 0);
	endfunction

	function automatic int rx_idle_pct();
		return sent_cnt < 350 ? 55 : (sent_cnt < 700 ? 21 : 0);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2, 3: return 16'($urandom_range(511) - 256);
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	task automatic check_field(input string name, input logic [SAMPLE_BITS-1:0] got,
			input logic [SAMPLE_BITS-1:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %0d expected %0d", name,
				$signed(got), $signed(want)));
	endtask

	task automatic write_coef(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [COEF_BITS-1:0] val);
		logic signed [COEF_BITS-1:0] sval;
		sval = val;
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_B0: coef_b0 = longint'(sval);
			REG_A1: coef_a1 = longint'(sval);
			REG_A2: coef_a2 = longint'(sval);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_item(input int ax, input int ay, input int az,
			input int gx, input int gy, input int gz);
		imu_in_t it;
		it.accel_x = 16'(ax);
		it.accel_y = 16'(ay);
		it.accel_z = 16'(az);
		it.gyro_x = 16'(gx);
		it.gyro_y = 16'(gy);
		it.gyro_z = 16'(gz);
		pend_q.push_back(it);
	endtask

	task automatic wait_idle();
		while (pend_q.size() != 0 || s_tvalid || imu_out_q.size() != 0)
			@(negedge clk);
		repeat (IDLE_GAP) @(negedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		if (!s_tvalid || beat_taken) begin
			beat_taken = 1'b0;
			if (pend_q.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
				s_tdata <= pend_q.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (!held && sent_cnt >= HOLD_AT) begin
			held = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct());
		end
	end

	always @(posedge clk) begin
		imu_out_t got, want;
		if (arst_n && s_tvalid && s_tready) begin
			imu_out_q.push_back(biquad_step(imu_in_t'(s_tdata)));
			sent_cnt++;
			beat_taken = 1'b1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = imu_out_t'(m_tdata);
			if (imu_out_q.size() == 0) begin
				flag_error("output beat with nothing expected");
			end else begin
				want = imu_out_q.pop_front();
				check_field("filtered_x", got.filtered_x, want.filtered_x);
				check_field("filtered_y", got.filtered_y, want.filtered_y);
				check_field("filtered_z", got.filtered_z, want.filtered_z);
				check_field("gyro_x_out", got.gyro_x_out, want.gyro_x_out);
				check_field("gyro_y_out", got.gyro_y_out, want.gyro_y_out);
				check_field("gyro_z_out", got.gyro_z_out, want.gyro_z_out);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int p, i;
		for (i = 0; i < 3; i++) begin
			delay_one[i] = 0;
			delay_two[i] = 0;
		end
		coef_b0 = 0;
		coef_a1 = 0;
		coef_a2 = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset coefficients give all-zero filtered outputs
		push_item(32767, -32768, 1, 16'h5555, 16'haaaa, -1);
		wait_idle();

		// unstable section: delay overflow and output saturation
		write_coef(REG_B0, 18'(131071));
		write_coef(REG_A1, 18'(-131072));
		write_coef(REG_A2, 18'(0));
		for (i = 0; i < 5; i++)
			push_item(32767, -32768, 0, 32767, -32768, 0);
		push_item(0, 0, 0, -1, 1, -1);
		push_item(-1, 1, -32768, 16'haaaa, 16'h5555, 32767);
		push_item(32767, 32767, 32767, 0, 0, 16'h8000);
		push_item(-32768, -32768, -32768, 16'h00ff, 16'hff00, 16'h0f0f);
		push_item(1, -1, 100, 16'hf0f0, 16'h1234, 16'hedcb);
		wait_idle();

		// opposite extremes, plus a write to an unmapped index
		write_coef(REG_B0, 18'(-131072));
		write_coef(REG_A1, 18'(131071));
		write_coef(REG_A2, 18'(-131072));
		write_coef(REG_NONE, 18'h15a5a);
		for (i = 0; i < 4; i++)
			push_item(-32768, 32767, 12345, i, -i, 16'h7fff);
		push_item(0, 0, 0, 0, 0, 0);
		push_item(32767, -32768, -1, -32768, 32767, 1);
		push_item(-100, 200, -300, 400, -500, 600);
		wait_idle();

		for (p = 0; p < PHASES; p++) begin
			if (b0_tab[p] == -1 && a1_tab[p] == -1) begin
				write_coef(REG_B0, 18'($urandom()));
				write_coef(REG_A1, 18'($urandom()));
				write_coef(REG_A2, 18'($urandom()));
			end else begin
				write_coef(REG_B0, 18'(b0_tab[p]));
				write_coef(REG_A1, 18'(a1_tab[p]));
				write_coef(REG_A2, 18'(a2_tab[p]));
			end
			if (p == 3)
				write_coef(REG_NONE, 18'($urandom()));
			for (i = 0; i < ITEMS_PER_PHASE; i++)
				push_item(pick_sample(), pick_sample(), pick_sample(),
					pick_sample(), pick_sample(), pick_sample());
			wait_idle();
		end

		repeat (20) @(negedge clk);
		if (err_cnt == 0 && imu_out_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
